@@ sv/mvm_pkg.sv @@
// shared constants, codes and types of the matrix-vector multiply unit
package mvm_pkg;

  localparam int unsigned VEC_DEPTH_DEF = 1024;

  localparam int unsigned ELEM_W     = 16;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned ROWS_W     = 16;
  localparam int unsigned RES_W      = 32;
  localparam int unsigned PROD_W     = 32;
  localparam int unsigned ACC_W      = 48;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_MATRIX = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_VEC_LEN   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 8'd1;

  localparam logic signed [RES_W-1:0] RES_MAX = 32'sh7fff_ffff;
  localparam logic signed [RES_W-1:0] RES_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic                     valid;
    logic signed [ELEM_W-1:0] value;
    logic                     last_col;
    logic [ROWS_W-1:0]        row_num;
    logic                     last_row;
  } issue_t;

endpackage

@@ sv/mvm_if.sv @@
// handshake channel interfaces of the matrix-vector multiply unit
interface mvm_in_if;
  logic                             valid;
  logic                             ready;
  logic                             operation;
  logic signed [mvm_pkg::ELEM_W-1:0] elem_value;
  logic [mvm_pkg::IDX_W-1:0]        vec_index;

  modport source (output valid, output operation, output elem_value, output vec_index,
                  input ready);
  modport sink   (input valid, input operation, input elem_value, input vec_index,
                  output ready);
endinterface

interface mvm_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [mvm_pkg::RES_W-1:0] row_result;
  logic [mvm_pkg::ROWS_W-1:0]       row_number;
  logic                             last_row;

  modport source (output valid, output row_result, output row_number, output last_row,
                  input ready);
  modport sink   (input valid, input row_result, input row_number, input last_row,
                  output ready);
endinterface

interface mvm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mvm_pkg::CFG_IDX_W-1:0]  index;
  logic [mvm_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/mvm_ram.sv @@
// generic single-port ram with registered read
module mvm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/mvm_seq.sv @@
// input acceptance, configuration registers, column and row counters, store access
module mvm_seq #(
  parameter int unsigned VEC_DEPTH = mvm_pkg::VEC_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mvm_in_if.sink                        in_i,
  mvm_cfg_if.sink                       cfg_i,
  input  logic                          mac_ready_i,
  output mvm_pkg::issue_t               issue_o,
  output logic                          ram_we_o,
  output logic                          ram_re_o,
  output logic [$clog2(VEC_DEPTH)-1:0]  ram_addr_o,
  output logic [mvm_pkg::ELEM_W-1:0]    ram_wdata_o
);

  localparam int unsigned AW = $clog2(VEC_DEPTH);
  localparam int unsigned EW = ((AW > mvm_pkg::LEN_W) ? AW : mvm_pkg::LEN_W) + 1;
  localparam int unsigned RW = mvm_pkg::ROWS_W + 1;

  logic [mvm_pkg::LEN_W-1:0]  vec_len_q, vec_len_d;
  logic [mvm_pkg::ROWS_W-1:0] row_count_q, row_count_d;
  logic [AW-1:0]              col_q, col_d;
  logic [mvm_pkg::ROWS_W-1:0] row_q, row_d;
  mvm_pkg::issue_t            issue_q, issue_d;

  logic          accept;
  logic          is_matrix;
  logic          idx_ok;
  logic [EW-1:0] vlen;
  logic [EW-1:0] eff_len;
  logic [RW-1:0] eff_rows;
  logic          last_col;
  logic          last_row;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !issue_q.valid || mac_ready_i;
  assign accept      = in_i.valid && in_i.ready;
  assign is_matrix   = (in_i.operation == mvm_pkg::OP_MATRIX);
  assign idx_ok      = 32'(in_i.vec_index) < 32'(VEC_DEPTH);

  // effective row length and row count
  always_comb begin
    vlen = EW'(vec_len_q);
    if (vlen == '0) begin
      eff_len = EW'(1);
    end else if (vlen > EW'(VEC_DEPTH)) begin
      eff_len = EW'(VEC_DEPTH);
    end else begin
      eff_len = vlen;
    end
    eff_rows = (row_count_q == '0) ? RW'(1) : RW'(row_count_q);
  end

  assign last_col = (EW'(col_q) + EW'(1)) >= eff_len;
  assign last_row = (RW'(row_q) + RW'(1)) >= eff_rows;

  assign ram_we_o    = accept && !is_matrix && idx_ok;
  assign ram_re_o    = accept && is_matrix;
  assign ram_addr_o  = is_matrix ? col_q : AW'(in_i.vec_index);
  assign ram_wdata_o = in_i.elem_value;

  always_comb begin
    vec_len_d   = vec_len_q;
    row_count_d = row_count_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        mvm_pkg::REG_VEC_LEN:   vec_len_d   = cfg_i.data[mvm_pkg::LEN_W-1:0];
        mvm_pkg::REG_ROW_COUNT: row_count_d = cfg_i.data[mvm_pkg::ROWS_W-1:0];
        default:                ;
      endcase
    end
  end

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    issue_d = issue_q;
    if (in_i.ready) begin
      issue_d.valid    = accept && is_matrix;
      issue_d.value    = in_i.elem_value;
      issue_d.last_col = last_col;
      issue_d.row_num  = row_q;
      issue_d.last_row = last_row;
    end
    if (accept && is_matrix && last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + 1'b1;
    end else if (accept && is_matrix) begin
      col_d = col_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_len_q   <= mvm_pkg::LEN_W'(1);
      row_count_q <= mvm_pkg::ROWS_W'(1);
      col_q       <= '0;
      row_q       <= '0;
      issue_q     <= '0;
    end else begin
      vec_len_q   <= vec_len_d;
      row_count_q <= row_count_d;
      col_q       <= col_d;
      row_q       <= row_d;
      issue_q     <= issue_d;
    end
  end

  assign issue_o = issue_q;

endmodule

@@ sv/mvm_mac.sv @@
// product register, 48-bit accumulator, saturation and result register
module mvm_mac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mvm_pkg::issue_t                   issue_i,
  input  logic signed [mvm_pkg::ELEM_W-1:0] x_i,
  output logic                              ready_o,
  mvm_out_if.source                         out_o
);

  logic                              p_valid_q, p_valid_d;
  logic signed [mvm_pkg::PROD_W-1:0] prod_q, prod_d;
  logic                              p_last_col_q, p_last_col_d;
  logic [mvm_pkg::ROWS_W-1:0]        p_row_q, p_row_d;
  logic                              p_last_row_q, p_last_row_d;
  logic signed [mvm_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic                              out_valid_q, out_valid_d;
  logic signed [mvm_pkg::RES_W-1:0]  res_q, res_d;
  logic [mvm_pkg::ROWS_W-1:0]        res_row_q, res_row_d;
  logic                              res_last_q, res_last_d;

  logic                              out_free;
  logic                              consume;
  logic signed [mvm_pkg::ACC_W-1:0]  sum;
  logic signed [mvm_pkg::RES_W-1:0]  sat;

  assign out_free = !out_valid_q || out_o.ready;
  assign consume  = p_valid_q && (!p_last_col_q || out_free);
  assign ready_o  = !p_valid_q || consume;

  assign sum = acc_q + mvm_pkg::ACC_W'(prod_q);

  // clamp to the signed 32-bit range
  always_comb begin
    if (sum[mvm_pkg::ACC_W-1:mvm_pkg::RES_W-1] == '0 ||
        sum[mvm_pkg::ACC_W-1:mvm_pkg::RES_W-1] == '1) begin
      sat = sum[mvm_pkg::RES_W-1:0];
    end else if (sum[mvm_pkg::ACC_W-1]) begin
      sat = mvm_pkg::RES_MIN;
    end else begin
      sat = mvm_pkg::RES_MAX;
    end
  end

  always_comb begin
    p_valid_d    = p_valid_q;
    prod_d       = prod_q;
    p_last_col_d = p_last_col_q;
    p_row_d      = p_row_q;
    p_last_row_d = p_last_row_q;
    acc_d        = acc_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    res_d        = res_q;
    res_row_d    = res_row_q;
    res_last_d   = res_last_q;
    if (ready_o) begin
      p_valid_d    = issue_i.valid;
      prod_d       = mvm_pkg::PROD_W'(issue_i.value) * mvm_pkg::PROD_W'(x_i);
      p_last_col_d = issue_i.last_col;
      p_row_d      = issue_i.row_num;
      p_last_row_d = issue_i.last_row;
    end
    if (consume && p_last_col_q) begin
      acc_d       = '0;
      out_valid_d = 1'b1;
      res_d       = sat;
      res_row_d   = p_row_q;
      res_last_d  = p_last_row_q;
    end else if (consume) begin
      acc_d = sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q   <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      p_valid_q   <= p_valid_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q       <= prod_d;
    p_last_col_q <= p_last_col_d;
    p_row_q      <= p_row_d;
    p_last_row_q <= p_last_row_d;
    res_q        <= res_d;
    res_row_q    <= res_row_d;
    res_last_q   <= res_last_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.row_result = res_q;
  assign out_o.row_number = res_row_q;
  assign out_o.last_row   = res_last_q;

endmodule

@@ sv/matrix_vector_multiply_unit.sv @@
// top level of the matrix-vector multiply unit
// Computes y = A*x over a stream of input words on in_i. A word with operation
// load writes elem_value into the vector store at vec_index (indexes at or
// beyond VEC_DEPTH are dropped) and gives no result. A word with operation
// matrix is one element of A in row-major order; it is multiplied by the stored
// vector element of the running column and summed. After vec_len elements one
// result word leaves on out_o: the Q16.16 row sum saturated to 32 bits, the
// row number and a flag on the last of row_count rows.
// cfg_i writes vec_len (index 0) and row_count (index 1); it is always ready;
// the user must write it only while the block is idle; the block does not enforce this.
// Throughput: one input word per cycle, loads and matrix elements alike, while out_o is not stalled.
// The last element of a row passes the issue register, then the product register;
// its accumulated row sum is then written into the result register that drives out_o.
// Reset sets vec_len and row_count to 1 and clears the accumulator and the
// counters; the vector store is not cleared and must be loaded before use.
// A stalled out_o holds its result; the pipeline keeps taking words until the
// next row end waits in the product register with one more word in the issue
// register behind it, then in_i.ready drops.
module matrix_vector_multiply_unit #(
  parameter int unsigned VEC_DEPTH = mvm_pkg::VEC_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mvm_in_if.sink    in_i,
  mvm_out_if.source out_o,
  mvm_cfg_if.sink   cfg_i
);

  localparam int unsigned AW = $clog2(VEC_DEPTH);

  mvm_pkg::issue_t             issue;
  logic                        mac_ready;
  logic                        ram_we;
  logic                        ram_re;
  logic [AW-1:0]               ram_addr;
  logic [mvm_pkg::ELEM_W-1:0]  ram_wdata;
  logic [mvm_pkg::ELEM_W-1:0]  ram_rdata;

  mvm_seq #(
    .VEC_DEPTH (VEC_DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_i),
    .mac_ready_i (mac_ready),
    .issue_o     (issue),
    .ram_we_o    (ram_we),
    .ram_re_o    (ram_re),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata)
  );

  mvm_ram #(
    .WIDTH (mvm_pkg::ELEM_W),
    .DEPTH (VEC_DEPTH)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  mvm_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (issue),
    .x_i     (ram_rdata),
    .ready_o (mac_ready),
    .out_o   (out_o)
  );

  a_matrix_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.operation == mvm_pkg::OP_MATRIX) |=> issue.valid)
    else $error("accepted matrix word not issued");

  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> issue.valid)
    else $error("input stalled with empty pipeline");

  a_issue_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue.valid && !mac_ready) |=> $stable(issue))
    else $error("stalled issue word changed");

endmodule
